FILE: src/utf8sd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

    localparam int unsigned CpWidth   = 31;
    localparam int unsigned LeftWidth = 3;

    // Lead byte class limits, highest byte value of each class
    localparam logic [7:0] LeadAscii = 8'h7F;
    localparam logic [7:0] LeadTwo   = 8'hDF;
    localparam logic [7:0] LeadThree = 8'hEF;
    localparam logic [7:0] LeadFour  = 8'hF7;
    localparam logic [7:0] LeadFive  = 8'hFB;
    localparam logic [7:0] LeadSix   = 8'hFD;
    localparam logic [7:0] ContMask  = 8'h3F;

    localparam logic [LeftWidth-1:0] MaxLeft = 3'd5;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [CpWidth-1:0] code_point;
        logic               cut_short;
    } t_out_item;

    // Decode step result: optional item plus the state for the next byte
    typedef struct packed {
        logic                 valid;
        t_out_item            item;
        logic [LeftWidth-1:0] bytes_left;
        logic [CpWidth-1:0]   acc;
    } t_step_res;

endpackage

FILE: src/utf8sd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8sd_step
// One decode step: current sequence state and one byte in, next state and
// an optional code point out. Purely combinational.
// ----------------------------------------------------------------------------
module utf8sd_step (
    input  logic [utf8sd_pkg::LeftWidth-1:0] i_bytes_left,
    input  logic [utf8sd_pkg::CpWidth-1:0]   i_acc,
    input  utf8sd_pkg::t_in_item             i_item,
    output utf8sd_pkg::t_step_res            o_res
);

    logic [7:0]                        w_ch;
    logic [utf8sd_pkg::LeftWidth-1:0]  w_left_clamp;
    logic [utf8sd_pkg::LeftWidth-1:0]  w_left_dec;
    logic [5:0]                        w_low6;
    logic [utf8sd_pkg::CpWidth-1:0]    w_cont;
    logic [utf8sd_pkg::CpWidth-1:0]    w_acc_cont;

    assign w_ch   = i_item.byte_in;
    assign w_low6 = w_ch[5:0] & utf8sd_pkg::ContMask[5:0];

    assign w_left_clamp = (i_bytes_left > utf8sd_pkg::MaxLeft) ? utf8sd_pkg::MaxLeft
                                                               : i_bytes_left;
    assign w_left_dec   = w_left_clamp - 3'd1;

    // six-bit slot select for the continuation byte
    always_comb begin
        unique case (w_left_dec)
            3'd0:    w_cont = {25'd0, w_low6};
            3'd1:    w_cont = {19'd0, w_low6, 6'd0};
            3'd2:    w_cont = {13'd0, w_low6, 12'd0};
            3'd3:    w_cont = {7'd0, w_low6, 18'd0};
            3'd4:    w_cont = {1'b0, w_low6, 24'd0};
            default: w_cont = '0;
        endcase
    end

    assign w_acc_cont = i_acc | w_cont;

    always_comb begin
        o_res = '0;
        if (i_bytes_left == '0) begin
            priority if (w_ch <= utf8sd_pkg::LeadAscii) begin
                o_res.valid           = 1'b1;
                o_res.item.code_point = {23'd0, w_ch};
            end else if (w_ch <= utf8sd_pkg::LeadTwo) begin
                o_res.acc        = {20'd0, w_ch[4:0], 6'd0};
                o_res.bytes_left = 3'd1;
            end else if (w_ch <= utf8sd_pkg::LeadThree) begin
                o_res.acc        = {15'd0, w_ch[3:0], 12'd0};
                o_res.bytes_left = 3'd2;
            end else if (w_ch <= utf8sd_pkg::LeadFour) begin
                o_res.acc        = {10'd0, w_ch[2:0], 18'd0};
                o_res.bytes_left = 3'd3;
            end else if (w_ch <= utf8sd_pkg::LeadFive) begin
                o_res.acc        = {5'd0, w_ch[1:0], 24'd0};
                o_res.bytes_left = 3'd4;
            end else if (w_ch <= utf8sd_pkg::LeadSix) begin
                o_res.acc        = {w_ch[0], 30'd0};
                o_res.bytes_left = 3'd5;
            end else begin
                // 0xFE / 0xFF: code point zero at once
                o_res.valid = 1'b1;
            end
            // string ends right after an opening lead
            if (o_res.bytes_left != '0 && i_item.last) begin
                o_res.valid           = 1'b1;
                o_res.item.code_point = o_res.acc;
                o_res.item.cut_short  = 1'b1;
                o_res.bytes_left      = '0;
                o_res.acc             = '0;
            end
        end else begin
            if (w_left_dec == '0) begin
                o_res.valid           = 1'b1;
                o_res.item.code_point = w_acc_cont;
            end else if (i_item.last) begin
                o_res.valid           = 1'b1;
                o_res.item.code_point = w_acc_cont;
                o_res.item.cut_short  = 1'b1;
            end else begin
                o_res.bytes_left = w_left_dec;
                o_res.acc        = w_acc_cont;
            end
        end
    end

endmodule

FILE: src/utf8_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-wide UTF-8 decoder: one byte per item, a code point out when a
// sequence completes or the string is cut short.
// ----------------------------------------------------------------------------
// A byte is registered at input, decoded, then registered at output or skid.
// Throughput: one byte per cycle while o_in_stall is low; the combinational
// decode step sets it. A two-entry output buffer (output register plus skid)
// absorbs stalls; o_in_stall rises only while the skid entry is occupied.
// Reset (synchronous, active low) empties the input register, output register
// and skid entry, and clears the sequence state to idle.
module utf8_stream_decoder (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  utf8sd_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output utf8sd_pkg::t_out_item o_out_item
);

    logic                             r_in_valid;
    utf8sd_pkg::t_in_item             r_in_item;
    logic [utf8sd_pkg::LeftWidth-1:0] r_bytes_left;
    logic [utf8sd_pkg::CpWidth-1:0]   r_acc;
    logic                             r_out_valid;
    utf8sd_pkg::t_out_item            r_out_item;
    logic                             r_skid_valid;
    utf8sd_pkg::t_out_item            r_skid_item;

    utf8sd_pkg::t_step_res            w_step;
    logic                             w_advance;
    logic                             w_in_accept;
    logic                             w_out_take;
    logic                             w_produce;

    utf8sd_step u_step (
        .i_bytes_left (r_bytes_left),
        .i_acc        (r_acc),
        .i_item       (r_in_item),
        .o_res        (w_step)
    );

    assign w_advance   = !r_skid_valid;
    assign w_in_accept = i_in_valid && !r_skid_valid;
    assign w_out_take  = r_out_valid && !i_out_stall;
    assign w_produce   = r_in_valid && w_advance && w_step.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_bytes_left <= '0;
            r_acc        <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_in_valid <= w_in_accept;
                if (r_in_valid) begin
                    r_bytes_left <= w_step.bytes_left;
                    r_acc        <= w_step.acc;
                end
            end

            // output register and skid entry
            if (r_skid_valid) begin
                if (w_out_take) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (w_produce) begin
                if (!r_out_valid || w_out_take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_item <= i_in_item;
        end
        if (r_skid_valid) begin
            if (w_out_take) begin
                r_out_item <= r_skid_item;
            end
        end else if (w_produce) begin
            if (!r_out_valid || w_out_take) begin
                r_out_item <= w_step.item;
            end else begin
                r_skid_item <= w_step.item;
            end
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry occupied with empty output register");

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_left <= utf8sd_pkg::MaxLeft)
        else $error("bytes_left out of range");

    a_idle_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bytes_left == '0) |-> (r_acc == '0))
        else $error("accumulator not cleared while idle");

    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_produce && r_out_valid && i_out_stall) |=> r_skid_valid)
        else $error("result lost while output stalled");

endmodule
